// File: rtl/rgbhsl_pkg.sv
// Shared types, constants and divider step for the RGB to HSL converter.
`timescale 1ns / 1ps

package rgbhsl_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CH_W       = 8;
	localparam int SUM_W      = CH_W + 1;
	localparam int DIV_W      = 11;
	localparam int QUO_W      = FRAC_BITS + 1;
	localparam int STEPS      = 4;
	localparam int DIV_STAGES = FRAC_BITS / STEPS;

	// floor(sum * 2^15 / 255) == (sum * 0x808081) >> 16 for every sum up to 510
	localparam int LIT_PROD_W = SUM_W + 24;
	localparam logic [LIT_PROD_W-1:0] LIT_RECIP = LIT_PROD_W'(24'h808081);
	localparam int LIT_SHIFT  = 16;

	localparam logic [SUM_W-1:0] SUM_FULL = SUM_W'(510);

	typedef struct packed {
		logic [DIV_W-1:0] hnum;
		logic [DIV_W-1:0] hden;
		logic [DIV_W-1:0] snum;
		logic [DIV_W-1:0] sden;
		logic [SUM_W-1:0] sum;
	} front_t;

	typedef struct packed {
		logic [DIV_W-1:0] hrem;
		logic [DIV_W-1:0] hden;
		logic [QUO_W-1:0] hquo;
		logic [DIV_W-1:0] srem;
		logic [DIV_W-1:0] sden;
		logic [QUO_W-1:0] squo;
		logic [FRAC_BITS-1:0] lit;
	} div_t;

	typedef struct packed {
		logic             q;
		logic [DIV_W-1:0] rem;
	} step_t;

	// one restoring step; rem < den on entry and on exit
	function automatic step_t div_step(input logic [DIV_W-1:0] rem, input logic [DIV_W-1:0] den);
		logic [DIV_W:0] dbl;
		step_t          res;
		dbl = {rem, 1'b0};
		if (dbl >= {1'b0, den}) begin
			res.q   = 1'b1;
			res.rem = DIV_W'(dbl - {1'b0, den});
		end else begin
			res.q   = 1'b0;
			res.rem = dbl[DIV_W-1:0];
		end
		return res;
	endfunction

endpackage

// File: rtl/rgbhsl_front.sv
// Stage 1: channel max/min, sum, span, hue numerator and divisors.
`timescale 1ns / 1ps

module rgbhsl_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [23:0]           color,
	output logic                  valid_s1,
	output rgbhsl_pkg::front_t    data_s1
);

	logic [rgbhsl_pkg::CH_W-1:0]  r, g, b, vmax, vmin, rg_max, rg_min, span;
	logic [rgbhsl_pkg::SUM_W-1:0] sum, sum_c;
	logic [rgbhsl_pkg::DIV_W-1:0] sp, sp3, sp5, sp6, hnum, dvb, dvg, dvr;
	rgbhsl_pkg::front_t           nxt;

	assign r = color[7:0];
	assign g = color[15:8];
	assign b = color[23:16];

	assign rg_max = (r >= g) ? r : g;
	assign rg_min = (r <= g) ? r : g;
	assign vmax   = (b > rg_max) ? b : rg_max;
	assign vmin   = (b < rg_min) ? b : rg_min;
	assign sum    = {1'b0, vmax} + {1'b0, vmin};
	assign sum_c  = rgbhsl_pkg::SUM_FULL - sum;
	assign span   = vmax - vmin;

	assign sp  = rgbhsl_pkg::DIV_W'(span);
	assign sp3 = (sp << 1) + sp;
	assign sp5 = (sp << 2) + sp;
	assign sp6 = (sp << 2) + (sp << 1);
	assign dvb = rgbhsl_pkg::DIV_W'(vmax - b);
	assign dvg = rgbhsl_pkg::DIV_W'(vmax - g);
	assign dvr = rgbhsl_pkg::DIV_W'(vmax - r);

	// sextant rule, red wins ties over green, green over blue
	always_comb begin
		if (r == vmax) begin
			hnum = (g == vmin) ? (sp5 + dvb) : (sp - dvg);
		end else if (g == vmax) begin
			hnum = (b == vmin) ? (sp + dvr) : (sp3 - dvb);
		end else begin
			hnum = (r == vmin) ? (sp3 + dvg) : (sp5 - dvr);
		end
	end

	always_comb begin
		nxt.sum = sum;
		if (span == '0) begin
			// grey or black: zero numerators give zero quotients
			nxt.hnum = '0;
			nxt.hden = rgbhsl_pkg::DIV_W'(1);
			nxt.snum = '0;
			nxt.sden = rgbhsl_pkg::DIV_W'(1);
		end else begin
			nxt.hnum = hnum;
			nxt.hden = sp6;
			nxt.snum = sp;
			nxt.sden = sum[rgbhsl_pkg::SUM_W-1] ? rgbhsl_pkg::DIV_W'(sum_c)
			                                    : rgbhsl_pkg::DIV_W'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

// File: rtl/rgbhsl_seed.sv
// Stage 2: leading quotient bit of both dividers and lightness.
`timescale 1ns / 1ps

module rgbhsl_seed (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  rgbhsl_pkg::front_t in_data,
	output logic               valid_s2,
	output rgbhsl_pkg::div_t   data_s2
);

	logic [rgbhsl_pkg::LIT_PROD_W-1:0] prod;
	logic [rgbhsl_pkg::QUO_W-1:0]      lit_raw;
	logic                              hq, sq;
	rgbhsl_pkg::div_t                  nxt;

	assign prod    = rgbhsl_pkg::LIT_PROD_W'(in_data.sum) * rgbhsl_pkg::LIT_RECIP;
	assign lit_raw = prod[rgbhsl_pkg::LIT_SHIFT +: rgbhsl_pkg::QUO_W];

	assign hq = (in_data.hnum >= in_data.hden);
	assign sq = (in_data.snum >= in_data.sden);

	always_comb begin
		nxt.hden = in_data.hden;
		nxt.sden = in_data.sden;
		nxt.hrem = hq ? (in_data.hnum - in_data.hden) : in_data.hnum;
		nxt.srem = sq ? (in_data.snum - in_data.sden) : in_data.snum;
		nxt.hquo = rgbhsl_pkg::QUO_W'(hq);
		nxt.squo = rgbhsl_pkg::QUO_W'(sq);
		nxt.lit  = lit_raw[rgbhsl_pkg::FRAC_BITS] ? '1 : lit_raw[rgbhsl_pkg::FRAC_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= nxt;
		end
	end

endmodule

// File: rtl/rgbhsl_div_stage.sv
// One divider stage: several restoring steps for hue and saturation.
`timescale 1ns / 1ps

module rgbhsl_div_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  rgbhsl_pkg::div_t in_data,
	output logic             out_valid,
	output rgbhsl_pkg::div_t out_data
);

	rgbhsl_pkg::div_t nxt;

	always_comb begin
		rgbhsl_pkg::step_t hs;
		rgbhsl_pkg::step_t ss;
		nxt = in_data;
		for (int k = 0; k < rgbhsl_pkg::STEPS; k++) begin
			hs       = rgbhsl_pkg::div_step(nxt.hrem, nxt.hden);
			ss       = rgbhsl_pkg::div_step(nxt.srem, nxt.sden);
			nxt.hrem = hs.rem;
			nxt.srem = ss.rem;
			nxt.hquo = {nxt.hquo[rgbhsl_pkg::QUO_W-2:0], hs.q};
			nxt.squo = {nxt.squo[rgbhsl_pkg::QUO_W-2:0], ss.q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

// File: rtl/rgb_to_hsl_converter.sv
// Top level: pipelined RGB to HSL converter.
//
//   channel | valid    | ready     | payload
//   input   | in_valid | in_ready  | color
//   output  | out_valid| out_ready | hue, saturation, lightness
//
// One pixel per clock sustained while the output is not stalled; stages are front, seed, 4 divider stages.
// The divider pipeline retires 4 quotient bits per stage for hue and saturation.
// Each stage advances when it is empty or the next one advances, so bubbles collapse.
// A stalled output holds its beat; upstream stages fill before in_ready drops.
// Async reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps

module rgb_to_hsl_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [23:0] color,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] hue,
	output logic [15:0] saturation,
	output logic [15:0] lightness
);

	localparam int NS = rgbhsl_pkg::DIV_STAGES;

	logic               valid_s1, en_front, en_seed;
	rgbhsl_pkg::front_t data_s1;
	logic [NS:0]        dv;
	logic [NS-1:0]      en_d;
	rgbhsl_pkg::div_t   dd [NS+1];

	assign en_front = !valid_s1 || en_seed;
	assign en_seed  = !dv[0] || en_d[0];
	assign in_ready = en_front;

	rgbhsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_front),
		.in_valid (in_valid),
		.color    (color),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	rgbhsl_seed u_seed (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_seed),
		.in_valid (valid_s1),
		.in_data  (data_s1),
		.valid_s2 (dv[0]),
		.data_s2  (dd[0])
	);

	for (genvar i = 0; i < NS; i++) begin : g_div
		if (i == NS - 1) begin : g_last
			assign en_d[i] = !dv[i+1] || out_ready;
		end else begin : g_mid
			assign en_d[i] = !dv[i+1] || en_d[i+1];
		end

		rgbhsl_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en_d[i]),
			.in_valid  (dv[i]),
			.in_data   (dd[i]),
			.out_valid (dv[i+1]),
			.out_data  (dd[i+1])
		);
	end

	// hue of exactly one wraps to zero; saturation of one clamps
	assign out_valid  = dv[NS];
	assign hue        = dd[NS].hquo[rgbhsl_pkg::FRAC_BITS-1:0];
	assign saturation = dd[NS].squo[rgbhsl_pkg::FRAC_BITS] ? '1
	                    : dd[NS].squo[rgbhsl_pkg::FRAC_BITS-1:0];
	assign lightness  = dd[NS].lit;

endmodule

// File: rtl/rgbhsl_checker.sv
// Port-level checks for the RGB to HSL converter, bound to the top level.
`timescale 1ns / 1ps

module rgbhsl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] hue,
	input logic [15:0] saturation,
	input logic [15:0] lightness
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hue) && $stable(saturation)
		&& $stable(lightness))
		else $error("output beat changed while stalled");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lightness == 16'h0000 |-> hue == 16'h0000 && saturation == 16'h0000)
		else $error("black beat with nonzero hue or saturation");

	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && lightness == 16'hFFFF |-> hue == 16'h0000 && saturation == 16'h0000)
		else $error("white beat with nonzero hue or saturation");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && !out_ready) ##1 !out_ready |-> !in_ready)
		else $error("input accepted while pipeline is stalled");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.hue        (hue),
	.saturation (saturation),
	.lightness  (lightness)
);
